### rtl/ec2c_pkg.sv
// ----------------------------------------------------------------------------
// ec2c_pkg: shared constants for the epoch seconds to calendar converter
// Field widths, input clamp limits, calendar constants and the month table.
// ----------------------------------------------------------------------------
package ec2c_pkg;

	// Field widths of the result word
	localparam int YEAR_W  = 7;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;

	// Input clamp, so that seconds plus half a day stays in 0 .. 2^31-1
	localparam int IN_LOW   = -43200;
	localparam int IN_HIGH  = 2147440447;
	localparam int HALF_DAY = 43200;

	// Shifted seconds, and its split by 86400 = 128 * 675
	localparam int T_W       = 31;
	localparam int DAY_SHIFT = 7;
	localparam int DAY_DIV   = 675;
	localparam int DAYNUM_W  = 15;
	localparam int DAYREM_W  = 10;
	localparam int SOD_W     = DAYREM_W + DAY_SHIFT;

	// Four-year cycle, leap year first (valid from 2000 up to 2099)
	localparam int CYCLE_DAYS = 1461;
	localparam int CYCLE_W    = 5;
	localparam int CYCDAY_W   = 11;
	localparam int LEAP_DAYS  = 366;
	localparam int YEAR_DAYS  = 365;
	localparam int DOY_W      = 9;

	// Seconds of the day split
	localparam int HOUR_SECS = 3600;
	localparam int HREM_W    = 12;
	localparam int MIN_SECS  = 60;

	// Result ranges and pipeline latency, accept edge to strobe edge
	localparam int MONTH_MAX  = 12;
	localparam int DAY_MAX    = 31;
	localparam int FEB        = 2;
	localparam int FEB_MAX    = 29;
	localparam int HOUR_MAX   = 23;
	localparam int MINSEC_MAX = 59;
	localparam int LATENCY    = 10;

	// First day of year of each month in a common year, January first
	localparam logic [DOY_W-1:0] MONTH_FIRST [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// First day of year of a month (index 0 is January), leap years shifted from March
	function automatic logic [DOY_W-1:0] month_first(input logic [3:0] idx, input logic leap);
		logic [DOY_W-1:0] base;
		base = MONTH_FIRST[idx];
		if (leap && (idx >= 4'd2)) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

### rtl/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 2000-01-01 12:00 to date and time
// Clamps the input, splits it into day number and seconds of day, converts
// the day number into year, month and day, and the seconds into h:m:s.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | word
//  ---------+----------------------+---------------------------------------
//  input    | start && !busy       | epoch_seconds (32 bit, signed)
//  result   | done, one cycle      | year_offset, month, day, hour, minute,
//           | (no back-pressure)   | second
//
//  A word can be taken in every cycle that busy is low; results come out in
//  the order their words were accepted. The latency is set by the chain of
//  three constant dividers (by 675, then by 3600, then by 60), three stages
//  each, behind one clamp stage. busy is high during reset and is cleared at
//  the first clock edge after it, then stays low: the pipeline never stalls
//  and the receiver has no way to hold results, so nothing waits anywhere.
//
//  Dates: day numbers from 2000-01-01 are split into four-year cycles that
//  start with a leap year, which is exact over the whole clamped range
//  (2000 through 2068).
//
module epoch_seconds_to_calendar (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [31:0]              epoch_seconds,
	output logic                            done,
	output logic [ec2c_pkg::YEAR_W-1:0]     year_offset,
	output logic [ec2c_pkg::MONTH_W-1:0]    month,
	output logic [ec2c_pkg::DAY_W-1:0]      day,
	output logic [ec2c_pkg::HOUR_W-1:0]     hour,
	output logic [ec2c_pkg::MIN_W-1:0]      minute,
	output logic [ec2c_pkg::SEC_W-1:0]      second
);

	logic busy_q;
	logic accept;

	// stage 1: clamp and shift to midnight
	logic                         v_s1;
	logic [ec2c_pkg::T_W-1:0]     t_s1;
	logic [ec2c_pkg::T_W-1:0]     t_next;

	// stages 2..4: day number and seconds of day
	logic [ec2c_pkg::DAY_SHIFT-1:0] lo_s2, lo_s3, lo_s4;
	logic                           v_s4;
	logic [ec2c_pkg::DAYNUM_W-1:0]  day_num;
	logic [ec2c_pkg::DAYREM_W-1:0]  day_rem_hi;
	logic [ec2c_pkg::SOD_W-1:0]     sod;

	// stages 5..7: four-year cycle and hour
	logic                           v_s7;
	logic [ec2c_pkg::CYCLE_W-1:0]   cyc;
	logic [ec2c_pkg::CYCDAY_W-1:0]  cyc_day;
	logic [ec2c_pkg::HOUR_W-1:0]    hour_w;
	logic [ec2c_pkg::HREM_W-1:0]    hour_rem;

	// stage 8: year within cycle, day of year
	logic [ec2c_pkg::CYCDAY_W-1:0]  past_leap;
	logic [1:0]                     yc;
	logic [ec2c_pkg::DOY_W-1:0]     doy;
	logic                           leap;
	logic [ec2c_pkg::YEAR_W-1:0]    yoff_s8;
	logic [ec2c_pkg::DOY_W-1:0]     doy_s8;
	logic                           leap_s8;
	logic [ec2c_pkg::HOUR_W-1:0]    hour_s8;

	// stage 9: month and day
	logic [3:0]                     mon_idx;
	logic [ec2c_pkg::DOY_W-1:0]     mon_base;
	logic [ec2c_pkg::YEAR_W-1:0]    yoff_s9;
	logic [ec2c_pkg::MONTH_W-1:0]   month_s9;
	logic [ec2c_pkg::DAY_W-1:0]     day_s9;
	logic [ec2c_pkg::HOUR_W-1:0]    hour_s9;

	// stage 10: result word
	logic                           v_s10;
	logic [ec2c_pkg::YEAR_W-1:0]    yoff_s10;
	logic [ec2c_pkg::MONTH_W-1:0]   month_s10;
	logic [ec2c_pkg::DAY_W-1:0]     day_s10;
	logic [ec2c_pkg::HOUR_W-1:0]    hour_s10;
	logic [ec2c_pkg::MIN_W-1:0]     min_w;
	logic [ec2c_pkg::SEC_W-1:0]     sec_w;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// Hold busy through reset, clear it at the first clock edge after reset and keep it low for good
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// Saturate out-of-range inputs, then add half a day
	always_comb begin
		if (epoch_seconds < ec2c_pkg::IN_LOW) begin
			t_next = '0;
		end else if (epoch_seconds > ec2c_pkg::IN_HIGH) begin
			t_next = '1;
		end else begin
			t_next = ec2c_pkg::T_W'(epoch_seconds + ec2c_pkg::HALF_DAY);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= t_next;
	end

	// Divide by 86400 as a shift by 7 and a division by 675; the low
	// seven bits ride alongside and rejoin the remainder.
	ec2c_divmod #(
		.XW  (ec2c_pkg::T_W - ec2c_pkg::DAY_SHIFT),
		.QW  (ec2c_pkg::DAYNUM_W),
		.RW  (ec2c_pkg::DAYREM_W),
		.DIV (ec2c_pkg::DAY_DIV)
	) u_day (
		.clk    (clk),
		.arst_n (arst_n),
		.vi     (v_s1),
		.x      (t_s1[ec2c_pkg::T_W-1:ec2c_pkg::DAY_SHIFT]),
		.vo     (v_s4),
		.q      (day_num),
		.r      (day_rem_hi)
	);

	always_ff @(posedge clk) begin
		lo_s2 <= t_s1[ec2c_pkg::DAY_SHIFT-1:0];
		lo_s3 <= lo_s2;
		lo_s4 <= lo_s3;
	end

	assign sod = {day_rem_hi, lo_s4};

	// Day number into four-year cycles
	ec2c_divmod #(
		.XW  (ec2c_pkg::DAYNUM_W),
		.QW  (ec2c_pkg::CYCLE_W),
		.RW  (ec2c_pkg::CYCDAY_W),
		.DIV (ec2c_pkg::CYCLE_DAYS)
	) u_cycle (
		.clk    (clk),
		.arst_n (arst_n),
		.vi     (v_s4),
		.x      (day_num),
		.vo     (),
		.q      (cyc),
		.r      (cyc_day)
	);

	// Seconds of day into hours, in step with the cycle split
	ec2c_divmod #(
		.XW  (ec2c_pkg::SOD_W),
		.QW  (ec2c_pkg::HOUR_W),
		.RW  (ec2c_pkg::HREM_W),
		.DIV (ec2c_pkg::HOUR_SECS)
	) u_hour (
		.clk    (clk),
		.arst_n (arst_n),
		.vi     (v_s4),
		.x      (sod),
		.vo     (v_s7),
		.q      (hour_w),
		.r      (hour_rem)
	);

	// Seconds of the hour into minutes and seconds
	ec2c_divmod #(
		.XW  (ec2c_pkg::HREM_W),
		.QW  (ec2c_pkg::MIN_W),
		.RW  (ec2c_pkg::SEC_W),
		.DIV (ec2c_pkg::MIN_SECS)
	) u_min (
		.clk    (clk),
		.arst_n (arst_n),
		.vi     (v_s7),
		.x      (hour_rem),
		.vo     (v_s10),
		.q      (min_w),
		.r      (sec_w)
	);

	// Year within the cycle: the first year has 366 days, the other three 365
	assign past_leap = cyc_day - ec2c_pkg::CYCDAY_W'(ec2c_pkg::LEAP_DAYS);

	always_comb begin
		if (cyc_day < ec2c_pkg::CYCDAY_W'(ec2c_pkg::LEAP_DAYS)) begin
			yc   = 2'd0;
			doy  = cyc_day[ec2c_pkg::DOY_W-1:0];
			leap = 1'b1;
		end else if (past_leap >= ec2c_pkg::CYCDAY_W'(2 * ec2c_pkg::YEAR_DAYS)) begin
			yc   = 2'd3;
			doy  = ec2c_pkg::DOY_W'(past_leap - ec2c_pkg::CYCDAY_W'(2 * ec2c_pkg::YEAR_DAYS));
			leap = 1'b0;
		end else if (past_leap >= ec2c_pkg::CYCDAY_W'(ec2c_pkg::YEAR_DAYS)) begin
			yc   = 2'd2;
			doy  = ec2c_pkg::DOY_W'(past_leap - ec2c_pkg::CYCDAY_W'(ec2c_pkg::YEAR_DAYS));
			leap = 1'b0;
		end else begin
			yc   = 2'd1;
			doy  = past_leap[ec2c_pkg::DOY_W-1:0];
			leap = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		yoff_s8 <= {cyc, yc};
		doy_s8  <= doy;
		leap_s8 <= leap;
		hour_s8 <= hour_w;
	end

	// Month: the last month whose first day is not past the day of year
	always_comb begin
		mon_idx  = 4'd0;
		mon_base = '0;
		for (int m = 0; m < 12; m++) begin
			if (doy_s8 >= ec2c_pkg::month_first(4'(m), leap_s8)) begin
				mon_idx  = 4'(m);
				mon_base = ec2c_pkg::month_first(4'(m), leap_s8);
			end
		end
	end

	always_ff @(posedge clk) begin
		yoff_s9  <= yoff_s8;
		month_s9 <= ec2c_pkg::MONTH_W'(mon_idx + 4'd1);
		day_s9   <= ec2c_pkg::DAY_W'(doy_s8 - mon_base + 9'd1);
		hour_s9  <= hour_s8;
	end

	// Align the date and hour with the minute divider's output
	always_ff @(posedge clk) begin
		yoff_s10  <= yoff_s9;
		month_s10 <= month_s9;
		day_s10   <= day_s9;
		hour_s10  <= hour_s9;
	end

	assign done        = v_s10;
	assign year_offset = yoff_s10;
	assign month       = month_s10;
	assign day         = day_s10;
	assign hour        = hour_s10;
	assign minute      = min_w;
	assign second      = sec_w;

endmodule

### rtl/ec2c_divmod.sv
// ----------------------------------------------------------------------------
// ec2c_divmod: pipelined division by a constant
// Three stages: reciprocal multiply, back-multiply and subtract, one-step fix.
// ----------------------------------------------------------------------------
module ec2c_divmod #(
	parameter int XW  = 24,
	parameter int QW  = 15,
	parameter int RW  = 10,
	parameter int DIV = 675
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vi,
	input  logic [XW-1:0] x,
	output logic          vo,
	output logic [QW-1:0] q,
	output logic [RW-1:0] r
);

	// floor(2^XW / DIV) keeps the estimate at most one below the quotient
	localparam int RECIP = (1 << XW) / DIV;
	localparam int REC_W = $clog2(RECIP + 1);
	localparam int PW    = XW + ((REC_W > QW) ? REC_W : QW);

	logic [PW-1:0] prod;
	logic [XW-1:0] diff;

	logic          v_s1, v_s2, v_s3;
	logic [XW-1:0] x_s1;
	logic [QW-1:0] q_s1, q_s2, q_s3;
	logic [RW:0]   rr_s2;
	logic [RW-1:0] r_s3;

	assign prod = PW'(x) * PW'(RECIP);
	assign diff = x_s1 - XW'(q_s1 * DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= vi;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1  <= x;
		q_s1  <= prod[XW+QW-1:XW];
		q_s2  <= q_s1;
		rr_s2 <= diff[RW:0];
		// correct an estimate that came out one short
		if (rr_s2 >= (RW+1)'(DIV)) begin
			q_s3 <= q_s2 + QW'(1);
			r_s3 <= RW'(rr_s2 - (RW+1)'(DIV));
		end else begin
			q_s3 <= q_s2;
			r_s3 <= rr_s2[RW-1:0];
		end
	end

	assign vo = v_s3;
	assign q  = q_s3;
	assign r  = r_s3;

endmodule

### rtl/ec2c_checker.sv
// ----------------------------------------------------------------------------
// ec2c_checker: port-level checks for the epoch seconds to calendar converter
// Latency, result ranges and the busy behavior, seen from the ports only.
// ----------------------------------------------------------------------------
module ec2c_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic [ec2c_pkg::MONTH_W-1:0]    month,
	input logic [ec2c_pkg::DAY_W-1:0]      day,
	input logic [ec2c_pkg::HOUR_W-1:0]     hour,
	input logic [ec2c_pkg::MIN_W-1:0]      minute,
	input logic [ec2c_pkg::SEC_W-1:0]      second
);

	// every accepted word yields a result after the fixed latency
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(ec2c_pkg::LATENCY) done)
		else $error("accepted word produced no result");

	// no result without an accepted word at the matching edge
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, ec2c_pkg::LATENCY))
		else $error("result without an accepted word");

	// result fields stay in calendar and clock ranges
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month >= 1 && month <= ec2c_pkg::MONTH_MAX &&
			day >= 1 && day <= ec2c_pkg::DAY_MAX &&
			hour <= ec2c_pkg::HOUR_MAX && minute <= ec2c_pkg::MINSEC_MAX &&
			second <= ec2c_pkg::MINSEC_MAX))
		else $error("result field out of range");

	// February never runs past its leap day
	a_february: assert property (@(posedge clk) disable iff (!arst_n)
		(done && month == ec2c_pkg::FEB) |-> (day <= ec2c_pkg::FEB_MAX))
		else $error("February day out of range");

	// once busy drops after reset it stays low
	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose outside reset");

endmodule

bind epoch_seconds_to_calendar ec2c_checker u_checker (.*);
